/* rtl/tlik_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared widths, constants, the CORDIC step table and the request type that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package tlik_pkg;

    // CORDIC and output angle format
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ANGLE_FRAC_BITS   = 12;
    localparam int ANG_Q             = 30;
    localparam int ROUND_SH          = ANG_Q - ANGLE_FRAC_BITS;

    // field widths
    localparam int COORD_W   = 16;
    localparam int LEN_W     = 14;
    localparam int ANG_OUT_W = 16;
    localparam int CFG_IDX_W = 8;

    // internal datapath widths
    localparam int R2_W      = 2 * COORD_W;
    localparam int A_W       = R2_W + 2;
    localparam int MAG_W     = 32;
    localparam int D_W       = 2 * MAG_W;
    localparam int SQ_IN_W   = 62;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int NORM_W    = 41;
    localparam int NORM_STAGES = 6;
    localparam int CX_W      = NORM_W + 3;
    localparam int ANG_W     = 35;
    localparam int CORDIC_LAT = NORM_STAGES + CORDIC_ITERATIONS;

    // request queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_LINK1 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LINK2 = CFG_IDX_W'(1);
    localparam logic [LEN_W-1:0]     LINK1_RESET = LEN_W'(6778);
    localparam logic [LEN_W-1:0]     LINK2_RESET = LEN_W'(9907);

    // angle constants, Q30 radians
    localparam logic signed [ANG_W-1:0] PI_Q30      = ANG_W'(64'd3373259426);
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'd1686629713);

    // rounding and saturation of the output angles
    localparam logic signed [ANG_W:0] ROUND_HALF = (ANG_W+1)'(1) <<< (ROUND_SH - 1);
    localparam logic signed [ANG_W:0] OUT_MAX    = (ANG_W+1)'(2**(ANG_OUT_W-1) - 1);
    localparam logic signed [ANG_W:0] OUT_MIN    = -(ANG_W+1)'(2**(ANG_OUT_W-1));

    // atan(2^-i) in Q30
    localparam logic [31:0] ATAN_STEP [24] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // classified request from front end to back end
    typedef struct packed {
        logic [SQ_IN_W-1:0]        n_e;      // radicand for elbow acos
        logic [SQ_IN_W-1:0]        n_h;      // radicand for helper acos
        logic [MAG_W-1:0]          m_e;      // |numerator| elbow
        logic [MAG_W-1:0]          m_h;      // |numerator| helper
        logic                      neg_e;
        logic                      clamp_e;
        logic                      neg_h;
        logic                      clamp_h;
        logic                      bad;
        logic                      ref_pos;
        logic                      tilt_neg;
        logic [COORD_W-1:0]        ax;
        logic [COORD_W-1:0]        ay;
        logic signed [COORD_W-1:0] z;
    } tlik_item_t;

endpackage
`default_nettype wire

/* rtl/two_link_planar_ik_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_planar_ik_core
// Inverse kinematics of a two-link planar arm: target point in, shoulder and
// elbow angles out, with z passed through and an out-of-reach flag.
//
//   channel   handshake              payload
//   ------    ---------------------  ------------------------------------------
//   in        in_valid / in_ready    x_coord, y_coord, z_coord, ref_elbow
//   out       out_valid / out_ready  shoulder_angle, elbow_angle, z_out,
//                                    unreachable
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (link1, link2)
//
// One request per cycle sustained while out_ready holds; a request passes the
// front pipe, the queue and a back end of 31 root stages + 22 angle stages + 3.
// Reset clears only control state and loads the default link lengths.
// A stalled output freezes the back end; the 4-entry queue then fills and
// the front end holds, dropping in_ready.
// ----------------------------------------------------------------------------
module two_link_planar_ik_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [tlik_pkg::COORD_W-1:0]    x_coord,
    input  logic signed [tlik_pkg::COORD_W-1:0]    y_coord,
    input  logic signed [tlik_pkg::COORD_W-1:0]    z_coord,
    input  logic signed [tlik_pkg::COORD_W-1:0]    ref_elbow,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tlik_pkg::ANG_OUT_W-1:0]  shoulder_angle,
    output logic signed [tlik_pkg::ANG_OUT_W-1:0]  elbow_angle,
    output logic signed [tlik_pkg::COORD_W-1:0]    z_out,
    output logic                                   unreachable,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tlik_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tlik_pkg::LEN_W-1:0]             cfg_data
);
    import tlik_pkg::*;

    logic       push, queue_full, pop, q_empty;
    tlik_item_t push_item, head;

    // front end: registers and classification
    tlik_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .z_coord    (z_coord),
        .ref_elbow  (ref_elbow),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // request queue
    tlik_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    // back end: roots, angles, branch and rounding
    tlik_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .shoulder_angle (shoulder_angle),
        .elbow_angle    (elbow_angle),
        .z_out          (z_out),
        .unreachable    (unreachable)
    );

endmodule
`default_nettype wire

/* rtl/tlik_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_front
// Holds the link registers, takes target points and works out the acos
// numerators, denominators and range flags in a six stage pipe.
// ----------------------------------------------------------------------------
module tlik_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tlik_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [tlik_pkg::COORD_W-1:0]  y_coord,
    input  logic signed [tlik_pkg::COORD_W-1:0]  z_coord,
    input  logic signed [tlik_pkg::COORD_W-1:0]  ref_elbow,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tlik_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tlik_pkg::LEN_W-1:0]           cfg_data,
    output logic                                 push,
    output tlik_pkg::tlik_item_t                 push_item,
    input  logic                                 queue_full
);
    import tlik_pkg::*;

    localparam int STAGES = 6;
    localparam int SQ_W   = 2 * LEN_W;
    localparam int PE_W   = 4 * LEN_W;
    localparam int DH_W   = R2_W + SQ_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic                      ref_pos;
        logic                      tilt_neg;
        logic [COORD_W-1:0]        ax;
        logic [COORD_W-1:0]        ay;
    } carry_t;

    logic [LEN_W-1:0]  link1_reg, link2_reg;
    logic [STAGES-1:0] vld_reg;
    logic              adv;

    carry_t            c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    carry_t            c1_next;
    logic [R2_W-2:0]   s1_xx_reg, s1_yy_reg;
    logic [SQ_W-1:0]   s1_l1sq_reg, s1_l2sq_reg;
    logic [R2_W-1:0]   s2_r2_reg;
    logic [PE_W-1:0]   s2_pe_reg;
    logic [SQ_W-1:0]   s2_l1sq_reg, s2_l2sq_reg;
    logic [A_W-1:0]    s3_ae_reg, s3_ah_reg;
    logic [DH_W-1:0]   s3_dh_reg;
    logic [PE_W-1:0]   s3_pe_reg;
    logic              s3_r2zero_reg, s4_r2zero_reg, s5_r2zero_reg;
    logic [MAG_W-1:0]  s4_me_reg, s4_mh_reg, s5_me_reg, s5_mh_reg;
    logic              s4_nege_reg, s4_negh_reg, s5_nege_reg, s5_negh_reg;
    logic [D_W-1:0]    s4_de_reg, s4_dh_reg, s5_de_reg, s5_dh_reg;
    logic [D_W-1:0]    s5_m2e_reg, s5_m2h_reg;
    tlik_item_t        item_reg, item_next;

    logic signed [R2_W-1:0] x_sq, y_sq;
    logic [A_W-1:0]    ae_neg, ah_neg;
    logic [D_W:0]      diff_e, diff_h;
    logic              bad_e, bad_h;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link1_reg <= LINK1_RESET;
            link2_reg <= LINK2_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LINK1: link1_reg <= cfg_data;
                REG_LINK2: link2_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // pipe control: the whole pipe holds when the last stage cannot push
    assign adv      = !vld_reg[STAGES-1] || !queue_full;
    assign in_ready = adv;
    assign push     = vld_reg[STAGES-1] && !queue_full;
    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
    end

    // stage 1: squares of the inputs and of the link lengths
    assign x_sq = x_coord * x_coord;
    assign y_sq = y_coord * y_coord;

    always_comb
    begin
        c1_next.z        = z_coord;
        c1_next.ref_pos  = !ref_elbow[COORD_W-1] && (ref_elbow != '0);
        c1_next.tilt_neg = x_coord[COORD_W-1] ^ y_coord[COORD_W-1];
        c1_next.ax       = x_coord[COORD_W-1] ? COORD_W'(-x_coord) : COORD_W'(x_coord);
        c1_next.ay       = y_coord[COORD_W-1] ? COORD_W'(-y_coord) : COORD_W'(y_coord);
    end

    // stage 3 magnitudes
    assign ae_neg = -s3_ae_reg;
    assign ah_neg = -s3_ah_reg;

    // stage 6: range check and radicands
    always_comb
    begin
        diff_e = {1'b0, s5_de_reg} - {1'b0, s5_m2e_reg};
        diff_h = {1'b0, s5_dh_reg} - {1'b0, s5_m2h_reg};
        bad_e  = (s5_de_reg == '0) || diff_e[D_W];
        bad_h  = (s5_dh_reg == '0) || diff_h[D_W];

        item_next.n_e      = diff_e[SQ_IN_W-1:0];
        item_next.n_h      = diff_h[SQ_IN_W-1:0];
        item_next.m_e      = s5_me_reg;
        item_next.m_h      = s5_mh_reg;
        item_next.neg_e    = s5_nege_reg;
        item_next.clamp_e  = bad_e;
        // target at origin: helper is forced to zero
        item_next.neg_h    = s5_negh_reg && !s5_r2zero_reg;
        item_next.clamp_h  = bad_h || s5_r2zero_reg;
        item_next.bad      = bad_e || bad_h || s5_r2zero_reg;
        item_next.ref_pos  = c5_reg.ref_pos;
        item_next.tilt_neg = c5_reg.tilt_neg;
        item_next.ax       = c5_reg.ax;
        item_next.ay       = c5_reg.ay;
        item_next.z        = c5_reg.z;
    end

    // pipe registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg      <= c1_next;
            s1_xx_reg   <= x_sq[R2_W-2:0];
            s1_yy_reg   <= y_sq[R2_W-2:0];
            s1_l1sq_reg <= link1_reg * link1_reg;
            s1_l2sq_reg <= link2_reg * link2_reg;

            c2_reg      <= c1_reg;
            s2_r2_reg   <= {1'b0, s1_xx_reg} + {1'b0, s1_yy_reg};
            s2_pe_reg   <= s1_l1sq_reg * s1_l2sq_reg;
            s2_l1sq_reg <= s1_l1sq_reg;
            s2_l2sq_reg <= s1_l2sq_reg;

            c3_reg        <= c2_reg;
            s3_ae_reg     <= A_W'(s2_r2_reg) - A_W'(s2_l1sq_reg) - A_W'(s2_l2sq_reg);
            s3_ah_reg     <= A_W'(s2_r2_reg) + A_W'(s2_l1sq_reg) - A_W'(s2_l2sq_reg);
            s3_dh_reg     <= s2_r2_reg * s2_l1sq_reg;
            s3_pe_reg     <= s2_pe_reg;
            s3_r2zero_reg <= (s2_r2_reg == '0);

            c4_reg        <= c3_reg;
            s4_nege_reg   <= s3_ae_reg[A_W-1];
            s4_negh_reg   <= s3_ah_reg[A_W-1];
            s4_me_reg     <= s3_ae_reg[A_W-1] ? ae_neg[MAG_W-1:0] : s3_ae_reg[MAG_W-1:0];
            s4_mh_reg     <= s3_ah_reg[A_W-1] ? ah_neg[MAG_W-1:0] : s3_ah_reg[MAG_W-1:0];
            s4_de_reg     <= D_W'({s3_pe_reg, 2'b00});
            s4_dh_reg     <= D_W'({s3_dh_reg, 2'b00});
            s4_r2zero_reg <= s3_r2zero_reg;

            c5_reg        <= c4_reg;
            s5_me_reg     <= s4_me_reg;
            s5_mh_reg     <= s4_mh_reg;
            s5_m2e_reg    <= s4_me_reg * s4_me_reg;
            s5_m2h_reg    <= s4_mh_reg * s4_mh_reg;
            s5_de_reg     <= s4_de_reg;
            s5_dh_reg     <= s4_dh_reg;
            s5_nege_reg   <= s4_nege_reg;
            s5_negh_reg   <= s4_negh_reg;
            s5_r2zero_reg <= s4_r2zero_reg;

            item_reg      <= item_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/tlik_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_queue
// Short request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tlik_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tlik_pkg::tlik_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output tlik_pkg::tlik_item_t head
);
    import tlik_pkg::*;

    tlik_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

/* rtl/tlik_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tlik_sqrt (
    input  logic                           clk,
    input  logic                           en,
    input  logic [tlik_pkg::SQ_IN_W-1:0]   radicand,
    output logic [tlik_pkg::SQ_OUT_W-1:0]  root
);
    import tlik_pkg::*;

    localparam int TW = SQ_IN_W + 2;

    logic [TW-1:0]       rem_reg [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] q_reg   [SQ_OUT_W];

    assign root = q_reg[SQ_OUT_W-1];

    for (genvar k = 0; k < SQ_OUT_W; k++)
    begin : g_stage
        localparam int B = SQ_OUT_W - 1 - k;
        logic [TW-1:0]       rem_in, trial;
        logic [SQ_OUT_W-1:0] q_in;

        if (k == 0)
        begin : g_first
            assign rem_in = TW'(radicand);
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
        assign trial = (TW'(q_in) << (B + 1)) + (TW'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[k] <= rem_in - trial;
                    q_reg[k]   <= q_in | (SQ_OUT_W'(1) << B);
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    q_reg[k]   <= q_in;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/tlik_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 for x, y >= 0.
// A normalising shifter lifts the leading one to the top bit first.
// ----------------------------------------------------------------------------
module tlik_cordic (
    input  logic                              clk,
    input  logic                              en,
    input  logic [tlik_pkg::MAG_W-1:0]        x_in,
    input  logic [tlik_pkg::MAG_W-1:0]        y_in,
    output logic signed [tlik_pkg::ANG_W-1:0] angle
);
    import tlik_pkg::*;

    logic [NORM_W-1:0]       nx_reg [NORM_STAGES];
    logic [NORM_W-1:0]       ny_reg [NORM_STAGES];
    logic signed [CX_W-1:0]  cx_reg [CORDIC_ITERATIONS];
    logic signed [CX_W-1:0]  cy_reg [CORDIC_ITERATIONS];
    logic signed [ANG_W-1:0] z_reg  [CORDIC_ITERATIONS];
    logic                    yz_reg [CORDIC_LAT];
    logic                    xz_reg [CORDIC_LAT];

    // zero operands bypass the iterations
    always_comb
    begin
        if (yz_reg[CORDIC_LAT-1])
            angle = '0;
        else if (xz_reg[CORDIC_LAT-1])
            angle = HALF_PI_Q30;
        else
            angle = z_reg[CORDIC_ITERATIONS-1];
    end

    // special-case flags ride along
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yz_reg[0] <= (y_in == '0);
            xz_reg[0] <= (x_in == '0);
            for (int k = 1; k < CORDIC_LAT; k++)
            begin
                yz_reg[k] <= yz_reg[k-1];
                xz_reg[k] <= xz_reg[k-1];
            end
        end
    end

    // normalising shifter, halving shift per stage
    for (genvar j = 0; j < NORM_STAGES; j++)
    begin : g_norm
        localparam int S = 1 << (NORM_STAGES - 1 - j);
        logic [NORM_W-1:0] nx_in, ny_in, both;

        if (j == 0)
        begin : g_first
            assign nx_in = NORM_W'(x_in);
            assign ny_in = NORM_W'(y_in);
        end
        else
        begin : g_next
            assign nx_in = nx_reg[j-1];
            assign ny_in = ny_reg[j-1];
        end

        assign both = nx_in | ny_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (both[NORM_W-1 -: S] == '0)
                begin
                    nx_reg[j] <= nx_in << S;
                    ny_reg[j] <= ny_in << S;
                end
                else
                begin
                    nx_reg[j] <= nx_in;
                    ny_reg[j] <= ny_in;
                end
            end
        end
    end

    // rotation stages
    for (genvar i = 0; i < CORDIC_ITERATIONS; i++)
    begin : g_iter
        logic signed [CX_W-1:0]  cx_in, cy_in, dx, dy;
        logic signed [ANG_W-1:0] z_in, step;

        if (i == 0)
        begin : g_first
            assign cx_in = $signed(CX_W'(nx_reg[NORM_STAGES-1]));
            assign cy_in = $signed(CX_W'(ny_reg[NORM_STAGES-1]));
            assign z_in  = '0;
        end
        else
        begin : g_next
            assign cx_in = cx_reg[i-1];
            assign cy_in = cy_reg[i-1];
            assign z_in  = z_reg[i-1];
        end

        assign dx   = cy_in >>> i;
        assign dy   = cx_in >>> i;
        assign step = $signed(ANG_W'(ATAN_STEP[i]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cy_in[CX_W-1] && (cy_in != '0))
                begin
                    cx_reg[i] <= cx_in + dx;
                    cy_reg[i] <= cy_in - dy;
                    z_reg[i]  <= z_in + step;
                end
                else
                begin
                    cx_reg[i] <= cx_in - dx;
                    cy_reg[i] <= cy_in + dy;
                    z_reg[i]  <= z_in - step;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/tlik_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_back
// Takes requests from the queue, runs the square roots and the three angle
// units, picks the elbow branch and rounds the joint angles.
// ----------------------------------------------------------------------------
module tlik_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  tlik_pkg::tlik_item_t                head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tlik_pkg::ANG_OUT_W-1:0] shoulder_angle,
    output logic signed [tlik_pkg::ANG_OUT_W-1:0] elbow_angle,
    output logic signed [tlik_pkg::COORD_W-1:0]   z_out,
    output logic                                unreachable
);
    import tlik_pkg::*;

    localparam int SB_LEN = SQ_OUT_W + CORDIC_LAT;
    localparam int LAT    = SB_LEN + 2;

    typedef struct packed {
        logic [MAG_W-1:0]          m_e;
        logic [MAG_W-1:0]          m_h;
        logic                      neg_e;
        logic                      clamp_e;
        logic                      neg_h;
        logic                      clamp_h;
        logic                      bad;
        logic                      ref_pos;
        logic                      tilt_neg;
        logic [COORD_W-1:0]        ax;
        logic [COORD_W-1:0]        ay;
        logic signed [COORD_W-1:0] z;
    } side_t;

    logic                    adv;
    logic [LAT-1:0]          vld_reg;
    logic                    out_valid_reg;
    side_t                   sb_reg [SB_LEN];
    side_t                   head_side, sq_side, end_side;
    logic [SQ_OUT_W-1:0]     root_e, root_h;
    logic signed [ANG_W-1:0] t_e, t_h, t_t;

    logic signed [ANG_W-1:0] e_raw_next, h_raw_next, tilt_next;
    logic signed [ANG_W-1:0] c1_e_reg, c1_h_reg, c1_tilt_reg;
    logic                    c1_ref_pos_reg, c1_bad_reg, c2_bad_reg;
    logic signed [COORD_W-1:0] c1_z_reg, c2_z_reg;
    logic                    flip;
    logic signed [ANG_W-1:0] c2_el_reg, c2_sh_reg;

    logic signed [ANG_OUT_W-1:0] shoulder_reg, elbow_reg;
    logic signed [COORD_W-1:0]   z_out_reg;
    logic                        unreachable_reg;

    // Q30 to output angle: round half up, then saturate
    function automatic logic signed [ANG_OUT_W-1:0] to_output(
        input logic signed [ANG_W-1:0] v
    );
        logic signed [ANG_W:0] s;
        logic signed [ANG_W:0] q;
        s = {v[ANG_W-1], v} + ROUND_HALF;
        q = s >>> ROUND_SH;
        if (q > OUT_MAX)
            q = OUT_MAX;
        else if (q < OUT_MIN)
            q = OUT_MIN;
        return q[ANG_OUT_W-1:0];
    endfunction

    // pipe control: everything holds while the result is not taken
    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && !q_empty;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], !q_empty};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    // side data follows the request through the roots and angle units
    always_comb
    begin
        head_side.m_e      = head.m_e;
        head_side.m_h      = head.m_h;
        head_side.neg_e    = head.neg_e;
        head_side.clamp_e  = head.clamp_e;
        head_side.neg_h    = head.neg_h;
        head_side.clamp_h  = head.clamp_h;
        head_side.bad      = head.bad;
        head_side.ref_pos  = head.ref_pos;
        head_side.tilt_neg = head.tilt_neg;
        head_side.ax       = head.ax;
        head_side.ay       = head.ay;
        head_side.z        = head.z;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= head_side;
            for (int k = 1; k < SB_LEN; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    assign sq_side  = sb_reg[SQ_OUT_W-1];
    assign end_side = sb_reg[SB_LEN-1];

    // square roots
    tlik_sqrt u_sqrt_e (
        .clk      (clk),
        .en       (adv),
        .radicand (head.n_e),
        .root     (root_e)
    );

    tlik_sqrt u_sqrt_h (
        .clk      (clk),
        .en       (adv),
        .radicand (head.n_h),
        .root     (root_h)
    );

    // angle units
    tlik_cordic u_cordic_e (
        .clk   (clk),
        .en    (adv),
        .x_in  (sq_side.m_e),
        .y_in  (MAG_W'(root_e)),
        .angle (t_e)
    );

    tlik_cordic u_cordic_h (
        .clk   (clk),
        .en    (adv),
        .x_in  (sq_side.m_h),
        .y_in  (MAG_W'(root_h)),
        .angle (t_h)
    );

    tlik_cordic u_cordic_t (
        .clk   (clk),
        .en    (adv),
        .x_in  (MAG_W'(sq_side.ax)),
        .y_in  (MAG_W'(sq_side.ay)),
        .angle (t_t)
    );

    // acos from atan: clamp or reflect for a negative numerator
    always_comb
    begin
        if (end_side.clamp_e)
            e_raw_next = end_side.neg_e ? PI_Q30 : '0;
        else
            e_raw_next = end_side.neg_e ? PI_Q30 - t_e : t_e;

        if (end_side.clamp_h)
            h_raw_next = end_side.neg_h ? PI_Q30 : '0;
        else
            h_raw_next = end_side.neg_h ? PI_Q30 - t_h : t_h;

        tilt_next = end_side.tilt_neg ? -t_t : t_t;
    end

    // branch choice: negative or zero reference, or a straight elbow
    assign flip = !c1_ref_pos_reg || (c1_e_reg == '0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_e_reg       <= e_raw_next;
            c1_h_reg       <= h_raw_next;
            c1_tilt_reg    <= tilt_next;
            c1_ref_pos_reg <= end_side.ref_pos;
            c1_bad_reg     <= end_side.bad;
            c1_z_reg       <= end_side.z;

            c2_el_reg  <= flip ? -c1_e_reg : c1_e_reg;
            c2_sh_reg  <= flip ? c1_tilt_reg + c1_h_reg : c1_tilt_reg - c1_h_reg;
            c2_bad_reg <= c1_bad_reg;
            c2_z_reg   <= c1_z_reg;

            shoulder_reg    <= to_output(c2_sh_reg);
            elbow_reg       <= to_output(c2_el_reg);
            z_out_reg       <= c2_z_reg;
            unreachable_reg <= c2_bad_reg;
        end
    end

    assign shoulder_angle = shoulder_reg;
    assign elbow_angle    = elbow_reg;
    assign z_out          = z_out_reg;
    assign unreachable    = unreachable_reg;

endmodule
`default_nettype wire
